@@ rtl/canny_non_max_suppression_assert.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef CANNY_NON_MAX_SUPPRESSION_ASSERT_SVH
`define CANNY_NON_MAX_SUPPRESSION_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define NMS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define NMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/nms_pkg.sv @@
`timescale 1ns / 1ps
package nms_pkg;

   localparam int MAG_W       = 8;
   localparam int ANGLE_W     = 10;
   localparam int SECTOR_W    = 2;
   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int ROW_W       = 12;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MIN_SIZE     = 3;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [SECTOR_W-1:0] SEC_HORIZ   = 2'd0;
   localparam logic [SECTOR_W-1:0] SEC_VERT    = 2'd1;
   localparam logic [SECTOR_W-1:0] SEC_MINUS45 = 2'd2;
   localparam logic [SECTOR_W-1:0] SEC_PLUS45  = 2'd3;

   // Sector bounds in half degrees: 22.5, 67.5, 112.5, 157.5 degrees.
   localparam logic signed [ANGLE_W-1:0] ANG_22P5  = 10'sd45;
   localparam logic signed [ANGLE_W-1:0] ANG_67P5  = 10'sd135;
   localparam logic signed [ANGLE_W-1:0] ANG_112P5 = 10'sd225;
   localparam logic signed [ANGLE_W-1:0] ANG_157P5 = 10'sd315;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [MAG_W-1:0]    mag;
   } pixel_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type cur;
   } column_type;

   typedef struct packed {
      column_type col;
      logic       has_result;
      logic       row_end;
      logic       frame_end;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic two_free;
   } qstat_type;

   function automatic logic [SECTOR_W-1:0] sector_of(input logic signed [ANGLE_W-1:0] h);
      logic [SECTOR_W-1:0] s;
      if ((h > -ANG_22P5 && h <= ANG_22P5) || h > ANG_157P5 || h <= -ANG_157P5) begin
         s = SEC_HORIZ;
      end else if ((h > -ANG_112P5 && h <= -ANG_67P5) || (h > ANG_67P5 && h <= ANG_112P5)) begin
         s = SEC_VERT;
      end else if ((h > -ANG_67P5 && h <= -ANG_22P5) || (h > ANG_112P5 && h <= ANG_157P5)) begin
         s = SEC_MINUS45;
      end else begin
         s = SEC_PLUS45;
      end
      return s;
   endfunction

endpackage

@@ rtl/nms_front.sv @@
`timescale 1ns / 1ps
module nms_front import nms_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MAG_W-1:0]      req_magnitude,
   input  logic [ANGLE_W-1:0]    req_angle_half_deg,
   input  qstat_type             q_stat,
   output logic                  q_push,
   output item_type              q_item
);

   localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RST_WIDTH = (MAX_WIDTH < RESET_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

   logic [COL_W-1:0] col_last_ff, col_last_in;
   logic [ROW_W-1:0] row_last_ff, row_last_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             s1_valid_ff;
   pixel_type        s1_cur_ff;
   logic [COL_W-1:0] s1_addr_ff;
   logic             s1_has_result_ff, s1_row_end_ff, s1_frame_end_ff;

   pixel_type mid_mem [MAX_WIDTH];
   pixel_type top_mem [MAX_WIDTH];
   pixel_type mid_rd_ff;
   pixel_type top_rd_ff;

   logic [12:0] wr_width, sat_width, wr_height, sat_height;
   logic        accept;
   logic        at_col_last;
   pixel_type   cur;

   assign req_ready   = s1_valid_ff ? q_stat.two_free : !q_stat.full;
   assign accept      = req_valid && req_ready;
   assign at_col_last = (col_ff == col_last_ff);
   assign cur.mag     = req_magnitude;
   assign cur.sector  = sector_of(req_angle_half_deg);

   always_comb begin
      wr_width  = {2'b00, csr_wdata[WIDTH_REG_W-1:0]};
      wr_height = csr_wdata[HEIGHT_REG_W-1:0];
      if (wr_width < 13'(MIN_SIZE)) begin
         sat_width = 13'(MIN_SIZE);
      end else if (wr_width > 13'(MAX_WIDTH)) begin
         sat_width = 13'(MAX_WIDTH);
      end else begin
         sat_width = wr_width;
      end
      if (wr_height < 13'(MIN_SIZE)) begin
         sat_height = 13'(MIN_SIZE);
      end else if (wr_height > 13'(MAX_HEIGHT)) begin
         sat_height = 13'(MAX_HEIGHT);
      end else begin
         sat_height = wr_height;
      end
   end

   always_comb begin
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  col_last_in = COL_W'(sat_width - 13'd1);
            CSR_IMAGE_HEIGHT: row_last_in = ROW_W'(sat_height - 13'd1);
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (at_col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= COL_W'(RST_WIDTH - 1);
         row_last_ff <= ROW_W'(RESET_HEIGHT - 1);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff        <= cur;
         s1_addr_ff       <= col_ff;
         s1_has_result_ff <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_row_end_ff    <= at_col_last;
         s1_frame_end_ff  <= at_col_last && (row_ff == row_last_ff);
      end
   end

   // Row above: read old entry, store the new pixel in its place.
   always_ff @(posedge clock) begin
      if (accept) begin
         mid_rd_ff    <= mid_mem[col_ff];
         mid_mem[col_ff] <= cur;
      end
   end

   // Row two above: the displaced middle entry is written in the cycle after its read.
   always_ff @(posedge clock) begin
      if (accept) begin
         top_rd_ff <= top_mem[col_ff];
      end
      if (s1_valid_ff) begin
         top_mem[s1_addr_ff] <= mid_rd_ff;
      end
   end

   assign q_push              = s1_valid_ff;
   assign q_item.col.top      = top_rd_ff;
   assign q_item.col.mid      = mid_rd_ff;
   assign q_item.col.cur      = s1_cur_ff;
   assign q_item.has_result   = s1_has_result_ff;
   assign q_item.row_end      = s1_row_end_ff;
   assign q_item.frame_end    = s1_frame_end_ff;

endmodule

@@ rtl/nms_queue.sv @@
`timescale 1ns / 1ps
module nms_queue import nms_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output item_type  head_item,
   output qstat_type stat
);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item     = entry_ff[rd_ptr_ff];
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.two_free = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

endmodule

@@ rtl/nms_back.sv @@
`timescale 1ns / 1ps
module nms_back import nms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  qstat_type        q_stat,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [MAG_W-1:0] rsp_thinned_value,
   output logic             rsp_row_end,
   output logic             rsp_frame_end
);

   // prev1 is the window's middle column, prev2 its left column.
   column_type       prev1_ff, prev2_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0] value_ff;
   logic             row_end_ff, frame_end_ff;

   logic [MAG_W-1:0] center, side_a, side_b, value_in;

   assign q_pop  = !q_stat.empty && (!rsp_valid_ff || rsp_ready);
   assign center = prev1_ff.mid.mag;

   always_comb begin
      unique case (prev1_ff.mid.sector)
         SEC_HORIZ: begin
            side_a = prev1_ff.cur.mag;
            side_b = prev1_ff.top.mag;
         end
         SEC_VERT: begin
            side_a = q_item.col.mid.mag;
            side_b = prev2_ff.mid.mag;
         end
         SEC_MINUS45: begin
            side_a = prev2_ff.cur.mag;
            side_b = q_item.col.top.mag;
         end
         SEC_PLUS45: begin
            side_a = q_item.col.cur.mag;
            side_b = prev2_ff.top.mag;
         end
      endcase
      value_in = (center < side_a || center < side_b) ? '0 : center;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = q_item.has_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev1_ff     <= '0;
         prev2_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            prev1_ff <= q_item.col;
            prev2_ff <= prev1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_item.has_result) begin
         value_ff     <= value_in;
         row_end_ff   <= q_item.row_end;
         frame_end_ff <= q_item.frame_end;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_thinned_value = value_ff;
   assign rsp_row_end       = row_end_ff;
   assign rsp_frame_end     = frame_end_ff;

endmodule

@@ rtl/canny_non_max_suppression.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Fields
// req      in         magnitude[7:0], angle_half_deg[9:0] signed
// rsp      out        thinned_value[7:0], row_end, frame_end
// csr      in         index 0 image_width[10:0], index 1 image_height[12:0]
//
// One pixel per clock sustained while rsp is not stalled; each accepted pixel passes
// the line store read register, the queue, and the compare and output register.
// The line store is one read and one write per cycle in each of its two rows.
// Reset restores 640 x 480 and clears counters; the line store is not cleared.
// A stalled rsp side fills the four-entry queue; req_ready drops once the queue
// cannot hold the beat in flight and one more, or is full with none in flight.
module canny_non_max_suppression import nms_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MAG_W-1:0]      req_magnitude,
   input  logic [ANGLE_W-1:0]    req_angle_half_deg,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [MAG_W-1:0]      rsp_thinned_value,
   output logic                  rsp_row_end,
   output logic                  rsp_frame_end
);

`include "canny_non_max_suppression_assert.svh"

   qstat_type q_stat;
   item_type  q_push_item, q_head_item;
   logic      q_push, q_pop;

   nms_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_magnitude      (req_magnitude),
      .req_angle_half_deg (req_angle_half_deg),
      .q_stat             (q_stat),
      .q_push             (q_push),
      .q_item             (q_push_item)
   );

   nms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .stat      (q_stat)
   );

   nms_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_stat            (q_stat),
      .q_item            (q_head_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_thinned_value (rsp_thinned_value),
      .rsp_row_end       (rsp_row_end),
      .rsp_frame_end     (rsp_frame_end)
   );

   `NMS_ASSERT_IMPL(a_push_room, clock, reset, q_push, !q_stat.full, "queue push while full")
   `NMS_ASSERT_IMPL(a_pop_data, clock, reset, q_pop, !q_stat.empty, "queue pop while empty")
   `NMS_ASSERT_NEXT(a_accept_push, clock, reset, req_valid && req_ready, q_push, "beat lost")
   `NMS_ASSERT_IMPL(a_frame_row, clock, reset, rsp_valid && rsp_frame_end, rsp_row_end, "frame end off row end")

endmodule

@@ verif/tb_canny_non_max_suppression.sv @@
`timescale 1ns / 1ps
module tb_canny_non_max_suppression import nms_pkg::*; ();

   localparam int LINE_DEPTH  = 1024;
   localparam int STALL_LIMIT = 2000;
   localparam int LATENCY     = 3;
   localparam int LONG_HOLD   = 120;
   localparam int PRINT_CAP   = 100;
   localparam int RANDOM_ITEMS = 480;
   localparam int TAIL_ROWS   = 40;

   typedef struct packed {
      logic [MAG_W-1:0]   mag;
      logic [ANGLE_W-1:0] angle;
   } pixel_beat_type;

   typedef struct packed {
      logic [MAG_W-1:0] value;
      logic             row_end;
      logic             frame_end;
   } thinned_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [MAG_W-1:0]    mag;
   } tap_type;

   logic                  clock;
   logic                  reset              = 1'b1;
   logic                  csr_we             = 1'b0;
   logic                  csr_index          = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata          = '0;
   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic [MAG_W-1:0]      req_magnitude      = '0;
   logic [ANGLE_W-1:0]    req_angle_half_deg = '0;
   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic [MAG_W-1:0]      rsp_thinned_value;
   logic                  rsp_row_end;
   logic                  rsp_frame_end;

   // shadow of the block's registers and storage
   logic [WIDTH_REG_W-1:0]  cfg_width  = WIDTH_REG_W'(RESET_WIDTH);
   logic [HEIGHT_REG_W-1:0] cfg_height = HEIGHT_REG_W'(RESET_HEIGHT);
   tap_type older_row [LINE_DEPTH];
   tap_type newer_row [LINE_DEPTH];
   tap_type win [3][3];
   int   col_pos = 0;
   int   row_pos = 0;

   pixel_beat_type pixel_q [$];
   thinned_type    thinned_q [$];
   pixel_beat_type next_px;
   thinned_type    want;

   int  pixels_queued   = 0;
   int  pixels_accepted = 0;
   int  results_seen    = 0;
   int  error_count     = 0;
   int  idle_cycles     = 0;
   int  src_gap         = 0;
   int  sink_gap        = 0;
   int  sink_hold       = 0;
   bit  src_gappy       = 1'b1;
   bit  sink_gappy      = 1'b1;
   bit  calm_tail       = 1'b0;

   int dir_angle [25] = '{-512, -360, -316, -315, -314, -226, -225, -224, -136, -135,
                          -134, -46, -45, -44, 0, 45, 46, 135, 136, 225,
                          226, 315, 316, 360, 511};
   int dir_mag [25]   = '{0, 255, 128, 255, 0, 255, 255, 7, 255, 1,
                          200, 100, 255, 100, 200, 0, 255, 255, 3, 255,
                          255, 0, 128, 255, 0};

   canny_non_max_suppression #(
      .MAX_WIDTH(LINE_DEPTH)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_magnitude      (req_magnitude),
      .req_angle_half_deg (req_angle_half_deg),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_thinned_value  (rsp_thinned_value),
      .rsp_row_end        (rsp_row_end),
      .rsp_frame_end      (rsp_frame_end)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int clamp_size(input int v, input int top_limit);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > top_limit) return top_limit;
      return v;
   endfunction

   // fold non-positive angles up by 360 half degrees and split into 45-degree-wide bins
   function automatic logic [SECTOR_W-1:0] quantize_angle(input logic [ANGLE_W-1:0] raw);
      int h;
      int g;
      h = $signed(raw);
      if (h <= -315) return SEC_HORIZ;
      g = (h <= 0) ? h + 360 : h;
      if (g <= 45 || g > 315) return SEC_HORIZ;
      if (g <= 135) return SEC_PLUS45;
      if (g <= 225) return SEC_VERT;
      return SEC_MINUS45;
   endfunction

   task automatic predict_pixel(input logic [MAG_W-1:0] mag, input logic [ANGLE_W-1:0] angle);
      int w;
      int ht;
      int c;
      int r;
      int y;
      tap_type fresh;
      tap_type up2;
      tap_type up1;
      tap_type ctr;
      logic [MAG_W-1:0] side_a;
      logic [MAG_W-1:0] side_b;
      thinned_type res;
      w = clamp_size(cfg_width, LINE_DEPTH);
      ht = clamp_size(cfg_height, MAX_HEIGHT);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= ht) ? ht - 1 : row_pos;
      fresh.sector = quantize_angle(angle);
      fresh.mag = mag;
      up2 = older_row[c];
      up1 = newer_row[c];
      older_row[c] = up1;
      newer_row[c] = fresh;
      for (y = 0; y < 3; y++) begin
         win[y][0] = win[y][1];
         win[y][1] = win[y][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = fresh;
      if (r >= 2 && c >= 2) begin
         ctr = win[1][1];
         side_a = '0;
         side_b = '0;
         case (ctr.sector)
            SEC_HORIZ: begin
               side_a = win[2][1].mag;
               side_b = win[0][1].mag;
            end
            SEC_VERT: begin
               side_a = win[1][2].mag;
               side_b = win[1][0].mag;
            end
            SEC_MINUS45: begin
               side_a = win[2][0].mag;
               side_b = win[0][2].mag;
            end
            SEC_PLUS45: begin
               side_a = win[2][2].mag;
               side_b = win[0][0].mag;
            end
         endcase
         res.value = (ctr.mag < side_a || ctr.mag < side_b) ? '0 : ctr.mag;
         res.row_end = (c == w - 1);
         res.frame_end = (c == w - 1) && (r == ht - 1);
         thinned_q.push_back(res);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= ht) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      if (error_count < PRINT_CAP)
         $display("mismatch on result %0d: %s got %0d, wanted %0d",
                  results_seen, what, got, exp_val);
      error_count++;
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_IMAGE_WIDTH) cfg_width = data[WIDTH_REG_W-1:0];
      else cfg_height = data[HEIGHT_REG_W-1:0];
      col_pos = 0;
      row_pos = 0;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_pixel(input int mag, input int angle);
      pixel_beat_type p;
      p.mag = MAG_W'(mag);
      p.angle = ANGLE_W'(angle);
      pixel_q.push_back(p);
      pixels_queued++;
   endtask

   task automatic queue_random_pixels(input int count);
      int flavor;
      int mag;
      int angle;
      flavor = $urandom_range(0, 3);
      repeat (count) begin
         case (flavor)
            0: mag = $urandom_range(0, 3);
            1: mag = $urandom_range(250, 255);
            default: mag = $urandom_range(0, 255);
         endcase
         if ($urandom_range(0, 4) == 0) angle = $urandom_range(0, 1023);
         else angle = $urandom_range(0, 720) - 360;
         queue_pixel(mag, angle);
      end
   endtask

   // hold until every pixel is in and every result is out, then let the pipe empty
   task automatic drain();
      while (pixels_accepted != pixels_queued || thinned_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_pixel(req_magnitude, req_angle_half_deg);
            pixels_accepted++;
            if (pixels_accepted % 50 == 0) src_gappy = ($urandom_range(0, 2) != 0);
            if (src_gappy && !calm_tail && $urandom_range(0, 5) == 0)
               src_gap = $urandom_range(1, 10);
         end
         if (!req_valid || req_ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
               next_px = pixel_q.pop_front();
               req_valid <= 1'b1;
               req_magnitude <= next_px.mag;
               req_angle_half_deg <= next_px.angle;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (thinned_q.size() == 0) begin
               report_mismatch("beat with nothing pending, value", rsp_thinned_value, 0);
            end else begin
               want = thinned_q.pop_front();
               if (rsp_thinned_value !== want.value)
                  report_mismatch("thinned_value", rsp_thinned_value, want.value);
               if (rsp_row_end !== want.row_end)
                  report_mismatch("row_end", rsp_row_end, want.row_end);
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch("frame_end", rsp_frame_end, want.frame_end);
            end
            results_seen++;
            if (results_seen % 50 == 0) sink_gappy = ($urandom_range(0, 2) != 0);
            if (!calm_tail && results_seen % 300 == 50) sink_hold = LONG_HOLD;
            else if (sink_gappy && !calm_tail && $urandom_range(0, 5) == 0)
               sink_gap = $urandom_range(1, 10);
         end
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[canny_non_max_suppression] ERROR");
         $finish;
      end
   end

   initial begin
      int i;
      int y;
      int x;
      int pick;
      int w;
      int ht;
      int count;
      int random_items;
      logic [CSR_DATA_W-1:0] data;
      random_items = 0;
      for (i = 0; i < LINE_DEPTH; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      for (y = 0; y < 3; y++)
         for (x = 0; x < 3; x++)
            win[y][x] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // boundary angles and extreme magnitudes on a 5x5 frame
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(5));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(5));
      for (i = 0; i < 25; i++) queue_pixel(dir_mag[i], dir_angle[i]);
      drain();

      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 2);
         if (pick != 1) begin
            data = ($urandom_range(0, 5) == 0) ? CSR_DATA_W'($urandom_range(0, 2))
                                               : CSR_DATA_W'($urandom_range(3, 16));
            data[12:11] = 2'($urandom_range(0, 3));
            write_csr(CSR_IMAGE_WIDTH, data);
         end
         if (pick != 0) begin
            data = ($urandom_range(0, 5) == 0) ? CSR_DATA_W'($urandom_range(0, 2))
                                               : CSR_DATA_W'($urandom_range(3, 8));
            write_csr(CSR_IMAGE_HEIGHT, data);
         end
         w = clamp_size(cfg_width, LINE_DEPTH);
         ht = clamp_size(cfg_height, MAX_HEIGHT);
         count = $urandom_range(1, 2) * w * ht;
         // partial frame, cut off by the next register write
         if ($urandom_range(0, 2) == 0) count += $urandom_range(1, w * ht - 1);
         queue_random_pixels(count);
         random_items += count;
         drain();
      end

      // tall frame, height saturated, with both sides running flat out
      calm_tail = 1'b1;
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(MIN_SIZE));
      write_csr(CSR_IMAGE_HEIGHT, 13'h1FFF);
      queue_random_pixels(MIN_SIZE * TAIL_ROWS);
      drain();

      if (error_count == 0) begin
         $display("[canny_non_max_suppression] OK");
      end else begin
         $display("[canny_non_max_suppression] ERROR");
      end
      $finish;
   end

endmodule

@@ canny_non_max_suppression.f @@
+incdir+rtl
rtl/nms_pkg.sv
rtl/nms_front.sv
rtl/nms_queue.sv
rtl/nms_back.sv
rtl/canny_non_max_suppression.sv
verif/tb_canny_non_max_suppression.sv
